@@ rtl/pbt_pkg.sv @@
// Shared types, codes and helpers of the placement bound tightener.
package pbt_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_XCON = 2'd1,
    OP_YCON = 2'd2,
    OP_READ = 2'd3
  } op_e;

  // One table row: a cell's box and its pitches.
  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] hi_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] hi_y;
    logic [15:0]        px;
    logic [15:0]        py;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // Clamp a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/pbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/placement_bound_tightener_unit.sv @@
// Top level of the placement bound tightener: cell box table, constraints, snapped reads.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------------
//  in      | to block  | in_valid_i / in_stall_o | op, cell/other index, distance, load box
//  out     | from block| out_valid_o/ out_stall_i| out_index, snapped xmin/xmax/ymin/ymax
//
//  A load item writes its row in the accepting cycle.
//  A constraint item reads row a, reads row b, raises lo(b), then lowers hi(a).
//  A read item runs the 32-step restoring remainder of the bound magnitudes by the
//  pitch (four lanes step together); an out-of-range read goes straight to the result.
//  Reset clears the sequencer and the output valid; the table is not cleared.
//  A finished read waits in its last state while the output register is stalled.
module placement_bound_tightener_unit #(
  parameter int unsigned MAX_CELLS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         cell_index_i,
  input  logic [7:0]         other_index_i,
  input  logic signed [31:0] min_distance_i,
  input  logic signed [31:0] load_xmin_i,
  input  logic signed [31:0] load_xmax_i,
  input  logic signed [31:0] load_ymin_i,
  input  logic signed [31:0] load_ymax_i,
  input  logic [15:0]        load_x_pitch_i,
  input  logic [15:0]        load_y_pitch_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_index_o,
  output logic signed [31:0] out_xmin_o,
  output logic signed [31:0] out_xmax_o,
  output logic signed [31:0] out_ymin_o,
  output logic signed [31:0] out_ymax_o
);

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned NL = 4;  // lanes: lo_x, hi_x, lo_y, hi_y

  // Sequencer codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;  // row a arrives (constraint)
  localparam logic [3:0] S_RDB  = 4'd2;  // row b arrives (constraint)
  localparam logic [3:0] S_LO   = 4'd3;  // raise lower bound of b
  localparam logic [3:0] S_HI   = 4'd4;  // lower upper bound of a
  localparam logic [3:0] S_RROW = 4'd5;  // row arrives (read)
  localparam logic [3:0] S_DIV  = 4'd6;  // remainder steps
  localparam logic [3:0] S_ADJ  = 4'd7;  // form snap offsets
  localparam logic [3:0] S_SAT  = 4'd8;  // add, clamp, present result

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q;

  // Item registers.
  pbt_pkg::op_e       op_q;
  logic [AW-1:0]      a_q, b_q;
  logic               oob_q;
  logic [7:0]         idx_q;
  logic signed [31:0] dist_q;
  pbt_pkg::row_t      row_a_q, row_b_q;

  // Remainder lanes.
  logic signed [31:0] val_q   [NL];
  logic [31:0]        dvd_q   [NL];
  logic [15:0]        rem_q   [NL];
  logic [15:0]        pit_q   [NL];
  logic               neg_q   [NL];
  logic signed [17:0] delta_q [NL];

  // Output register.
  logic [7:0]         out_index_q;
  logic signed [31:0] out_xmin_q, out_xmax_q, out_ymin_q, out_ymax_q;

  // RAM port.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  pbt_pkg::row_t      ram_wdata, ram_rdata;

  logic accept, a_ok, b_ok, out_free, is_x;
  logic signed [33:0] add_a, add_b, add_sum;
  logic signed [31:0] add_sat;
  logic signed [31:0] lo_a_sel, lo_b_sel, hi_a_sel, hi_b_sel;
  pbt_pkg::row_t      row_b_new, row_a_new, load_row;

  logic signed [31:0] lane_v   [NL];
  logic [15:0]        lane_p   [NL];
  logic [16:0]        step_t   [NL];
  logic [15:0]        step_r   [NL];
  logic signed [17:0] adj_d    [NL];
  logic signed [31:0] lane_out [NL];

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign a_ok       = (int'(cell_index_i) < int'(MAX_CELLS));
  assign b_ok       = (int'(other_index_i) < int'(MAX_CELLS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_x       = (op_q == pbt_pkg::OP_XCON);

  // Shared saturating adder for both constraint updates.
  always_comb begin
    lo_a_sel = is_x ? row_a_q.lo_x : row_a_q.lo_y;
    hi_a_sel = is_x ? row_a_q.hi_x : row_a_q.hi_y;
    lo_b_sel = is_x ? row_b_q.lo_x : row_b_q.lo_y;
    hi_b_sel = is_x ? row_b_q.hi_x : row_b_q.hi_y;
    if (state_q == S_LO) begin
      add_a = 34'(lo_a_sel);
      add_b = 34'(dist_q);
    end else begin
      add_a = 34'(hi_b_sel);
      add_b = -34'(dist_q);
    end
    add_sum = add_a + add_b;
    add_sat = pbt_pkg::sat34(add_sum);
  end

  // Tightened rows: raise lo(b) to the sum, drop hi(a) to the difference.
  always_comb begin
    row_b_new = row_b_q;
    if (add_sat > lo_b_sel) begin
      if (is_x) begin
        row_b_new.lo_x = add_sat;
      end else begin
        row_b_new.lo_y = add_sat;
      end
    end
    row_a_new = row_a_q;
    if (add_sat < hi_a_sel) begin
      if (is_x) begin
        row_a_new.hi_x = add_sat;
      end else begin
        row_a_new.hi_y = add_sat;
      end
    end
  end

  assign load_row = '{lo_x: load_xmin_i, hi_x: load_xmax_i, lo_y: load_ymin_i,
                      hi_y: load_ymax_i, px: load_x_pitch_i, py: load_y_pitch_i};

  // Table port: write on load, on each constraint update; read a, then b.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cell_index_i);
    ram_wdata = load_row;
    ram_raddr = AW'(cell_index_i);
    unique case (state_q)
      S_IDLE: begin
        ram_we = accept && (pbt_pkg::op_e'(op_i) == pbt_pkg::OP_LOAD) && a_ok;
      end
      S_RDA: begin
        ram_raddr = b_q;
      end
      S_LO: begin
        ram_we    = 1'b1;
        ram_waddr = b_q;
        ram_wdata = row_b_new;
      end
      S_HI: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = row_a_new;
      end
      default: begin
      end
    endcase
  end

  pbt_ram #(
    .WIDTH(pbt_pkg::ROW_W),
    .DEPTH(MAX_CELLS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Lane setup from the row read for a snapped read.
  always_comb begin
    lane_v[0] = ram_rdata.lo_x;
    lane_v[1] = ram_rdata.hi_x;
    lane_v[2] = ram_rdata.lo_y;
    lane_v[3] = ram_rdata.hi_y;
    lane_p[0] = ram_rdata.px;
    lane_p[1] = ram_rdata.px;
    lane_p[2] = ram_rdata.py;
    lane_p[3] = ram_rdata.py;
  end

  // One restoring remainder step, an offset and a clamp per lane.
  // Even lanes round up, odd lanes round down.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      step_t[i] = {rem_q[i], dvd_q[i][31]};
      if (step_t[i] >= {1'b0, pit_q[i]}) begin
        step_r[i] = 16'(step_t[i] - {1'b0, pit_q[i]});
      end else begin
        step_r[i] = step_t[i][15:0];
      end
      if ((pit_q[i] == 16'd0) || (rem_q[i] == 16'd0)) begin
        adj_d[i] = 18'sd0;
      end else if ((i % 2) == 0) begin
        adj_d[i] = neg_q[i] ? $signed({2'b00, rem_q[i]})
                            : $signed({2'b00, pit_q[i]} - {2'b00, rem_q[i]});
      end else begin
        adj_d[i] = neg_q[i] ? $signed({2'b00, rem_q[i]} - {2'b00, pit_q[i]})
                            : $signed(18'd0 - {2'b00, rem_q[i]});
      end
      lane_out[i] = pbt_pkg::sat34(34'(val_q[i]) + 34'(delta_q[i]));
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (pbt_pkg::op_e'(op_i))
            pbt_pkg::OP_LOAD: state_d = S_IDLE;
            pbt_pkg::OP_XCON,
            pbt_pkg::OP_YCON: state_d = (a_ok && b_ok) ? S_RDA : S_IDLE;
            pbt_pkg::OP_READ: state_d = a_ok ? S_RROW : S_SAT;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_LO;
      S_LO:   state_d = S_HI;
      S_HI:   state_d = S_IDLE;
      S_RROW: begin
        state_d = S_DIV;
        cnt_d   = 5'd31;
      end
      S_DIV: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = S_ADJ;
        end
      end
      S_ADJ:  state_d = S_SAT;
      S_SAT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if ((state_q == S_SAT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= pbt_pkg::op_e'(op_i);
      a_q    <= AW'(cell_index_i);
      b_q    <= AW'(other_index_i);
      idx_q  <= cell_index_i;
      oob_q  <= !a_ok;
      dist_q <= min_distance_i;
    end
    if (state_q == S_RDA) begin
      row_a_q <= ram_rdata;
    end
    if (state_q == S_RDB) begin
      row_b_q <= ram_rdata;
    end
    // Same cell on both sides: carry the raised lower bound into row a.
    if ((state_q == S_LO) && (a_q == b_q)) begin
      row_a_q <= row_b_new;
    end
    for (int i = 0; i < NL; i++) begin
      if (state_q == S_RROW) begin
        val_q[i] <= lane_v[i];
        neg_q[i] <= lane_v[i][31];
        dvd_q[i] <= lane_v[i][31] ? (32'd0 - lane_v[i]) : lane_v[i];
        rem_q[i] <= 16'd0;
        pit_q[i] <= lane_p[i];
      end else if (state_q == S_DIV) begin
        dvd_q[i] <= {dvd_q[i][30:0], 1'b0};
        rem_q[i] <= step_r[i];
      end
      if (state_q == S_ADJ) begin
        delta_q[i] <= adj_d[i];
      end
    end
    if ((state_q == S_SAT) && out_free) begin
      out_index_q <= idx_q;
      out_xmin_q  <= oob_q ? 32'sd0 : lane_out[0];
      out_xmax_q  <= oob_q ? 32'sd0 : lane_out[1];
      out_ymin_q  <= oob_q ? 32'sd0 : lane_out[2];
      out_ymax_q  <= oob_q ? 32'sd0 : lane_out[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_xmin_o  = out_xmin_q;
  assign out_xmax_o  = out_xmax_q;
  assign out_ymin_o  = out_ymin_q;
  assign out_ymax_o  = out_ymax_q;

  // A new result only ever comes out of the final read state.
  a_result_from_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_SAT)
    else $error("result raised outside the final read state");

  // The table is never written while remainder steps run.
  a_no_write_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !ram_we)
    else $error("table write during remainder steps");

  // A constraint update of row b is always followed by the update of row a.
  a_lo_then_hi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LO) |=> (state_q == S_HI) && ram_we)
    else $error("constraint sequence broken");

  // A free output register lets the finished read leave at once.
  a_sat_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SAT) && out_free |=> (state_q == S_IDLE) && out_valid_o)
    else $error("finished read did not retire");

endmodule

@@ test/tb_placement_bound_tightener_unit.sv @@
// Testbench of the placement bound tightener: items checked against a shadow cell table.
module tb_placement_bound_tightener_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CELLS        = 256;
  localparam int          CLK_HALF     = 6;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_START   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam int     BOUND_MAX = 32'sh7FFF_FFFF;
  localparam int     BOUND_MIN = 32'sh8000_0000;
  localparam longint WIDE_MAX  = BOUND_MAX;
  localparam longint WIDE_MIN  = BOUND_MIN;
  localparam int     AXIS_X    = 0;
  localparam int     AXIS_Y    = 1;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_e;

  // One input item as offered on the input channel.
  typedef struct {
    pbt_pkg::op_e op;
    logic [7:0]   cell_idx;
    logic [7:0]   other_idx;
    int           distance;
    int           xmin;
    int           xmax;
    int           ymin;
    int           ymax;
    logic [15:0]  px;
    logic [15:0]  py;
  } tightener_item_t;

  // One snapped box as returned on the output channel.
  typedef struct {
    logic [7:0]         cell_idx;
    logic signed [31:0] xmin;
    logic signed [31:0] xmax;
    logic signed [31:0] ymin;
    logic signed [31:0] ymax;
  } snapped_box_t;

  // Shadow copy of the cell table plus the boxes that reads still owe us.
  class box_scoreboard;
    int           lo_bound [2][CELLS];
    int           hi_bound [2][CELLS];
    bit [15:0]    pitch    [2][CELLS];
    snapped_box_t pending_boxes [$];
    int unsigned  fail_count;

    function new();
      fail_count = 0;
    endfunction

    static function int clamp32(longint v);
      if (v > WIDE_MAX) begin
        return BOUND_MAX;
      end
      if (v < WIDE_MIN) begin
        return BOUND_MIN;
      end
      return int'(v);
    endfunction

    // Floor modulo: the remainder always lies in [0, p).
    static function longint floor_mod(int v, bit [15:0] p);
      longint wide_p;
      longint r;
      wide_p = longint'(p);
      r = longint'(v) % wide_p;
      if (r < 0) begin
        r += wide_p;
      end
      return r;
    endfunction

    static function int snap_up(int v, bit [15:0] p);
      longint r;
      if (p == 0) begin
        return v;
      end
      r = floor_mod(v, p);
      if (r == 0) begin
        return v;
      end
      return clamp32(longint'(v) + longint'(p) - r);
    endfunction

    static function int snap_down(int v, bit [15:0] p);
      if (p == 0) begin
        return v;
      end
      return clamp32(longint'(v) - floor_mod(v, p));
    endfunction

    function void note_item(tightener_item_t it);
      int           axis;
      int           raised;
      int           lowered;
      snapped_box_t box;
      case (it.op)
        pbt_pkg::OP_LOAD: begin
          lo_bound[AXIS_X][it.cell_idx] = it.xmin;
          hi_bound[AXIS_X][it.cell_idx] = it.xmax;
          lo_bound[AXIS_Y][it.cell_idx] = it.ymin;
          hi_bound[AXIS_Y][it.cell_idx] = it.ymax;
          pitch[AXIS_X][it.cell_idx]    = it.px;
          pitch[AXIS_Y][it.cell_idx]    = it.py;
        end
        pbt_pkg::OP_XCON, pbt_pkg::OP_YCON: begin
          axis = (it.op == pbt_pkg::OP_YCON) ? AXIS_Y : AXIS_X;
          // raise the second cell's lower bound first, then lower the first cell's upper bound
          raised = clamp32(longint'(lo_bound[axis][it.cell_idx]) + longint'(it.distance));
          if (raised > lo_bound[axis][it.other_idx]) begin
            lo_bound[axis][it.other_idx] = raised;
          end
          lowered = clamp32(longint'(hi_bound[axis][it.other_idx]) - longint'(it.distance));
          if (lowered < hi_bound[axis][it.cell_idx]) begin
            hi_bound[axis][it.cell_idx] = lowered;
          end
        end
        default: begin
          box.cell_idx = it.cell_idx;
          box.xmin = snap_up(lo_bound[AXIS_X][it.cell_idx], pitch[AXIS_X][it.cell_idx]);
          box.xmax = snap_down(hi_bound[AXIS_X][it.cell_idx], pitch[AXIS_X][it.cell_idx]);
          box.ymin = snap_up(lo_bound[AXIS_Y][it.cell_idx], pitch[AXIS_Y][it.cell_idx]);
          box.ymax = snap_down(hi_bound[AXIS_Y][it.cell_idx], pitch[AXIS_Y][it.cell_idx]);
          pending_boxes.push_back(box);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] cell_idx,
                                logic signed [31:0] want_v, logic signed [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: cell %0d %s mismatch: expected %0d, actual %0d",
                 $time, cell_idx, name, want_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_box(snapped_box_t got);
      snapped_box_t want;
      if (pending_boxes.size() == 0) begin
        $display("%0t: box with none expected: actual cell %0d xmin %0d xmax %0d ymin %0d ymax %0d",
                 $time, got.cell_idx, got.xmin, got.xmax, got.ymin, got.ymax);
        fail_count++;
        return;
      end
      want = pending_boxes.pop_front();
      compare_field("out_index", want.cell_idx, 32'(want.cell_idx), 32'(got.cell_idx));
      compare_field("out_xmin", want.cell_idx, want.xmin, got.xmin);
      compare_field("out_xmax", want.cell_idx, want.xmax, got.xmax);
      compare_field("out_ymin", want.cell_idx, want.ymin, got.ymin);
      compare_field("out_ymax", want.cell_idx, want.ymax, got.ymax);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         op_i;
  logic [7:0]         cell_index_i;
  logic [7:0]         other_index_i;
  logic signed [31:0] min_distance_i;
  logic signed [31:0] load_xmin_i;
  logic signed [31:0] load_xmax_i;
  logic signed [31:0] load_ymin_i;
  logic signed [31:0] load_ymax_i;
  logic [15:0]        load_x_pitch_i;
  logic [15:0]        load_y_pitch_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         out_index_o;
  logic signed [31:0] out_xmin_o;
  logic signed [31:0] out_xmax_o;
  logic signed [31:0] out_ymin_o;
  logic signed [31:0] out_ymax_o;

  box_scoreboard boxes;

  // Cells written so far; reads and constraints only ever name these.
  logic [7:0]  loaded_cells [$];
  bit          cell_loaded [CELLS];
  int unsigned burst_left;

  placement_bound_tightener_unit #(
    .MAX_CELLS(CELLS)
  ) i_dut (.*);

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------------

  // Fill every field at random so that fields an operation ignores still toggle.
  function automatic tightener_item_t scrambled_item();
    tightener_item_t it;
    it.op        = pbt_pkg::OP_READ;
    it.cell_idx  = 8'($urandom);
    it.other_idx = 8'($urandom);
    it.distance  = int'($urandom);
    it.xmin      = int'($urandom);
    it.xmax      = int'($urandom);
    it.ymin      = int'($urandom);
    it.ymax      = int'($urandom);
    it.px        = 16'($urandom);
    it.py        = 16'($urandom);
    return it;
  endfunction

  function automatic tightener_item_t load_item(logic [7:0] cell_idx, int xmin, int xmax,
                                                int ymin, int ymax,
                                                logic [15:0] px, logic [15:0] py);
    tightener_item_t it;
    it          = scrambled_item();
    it.op       = pbt_pkg::OP_LOAD;
    it.cell_idx = cell_idx;
    it.xmin     = xmin;
    it.xmax     = xmax;
    it.ymin     = ymin;
    it.ymax     = ymax;
    it.px       = px;
    it.py       = py;
    return it;
  endfunction

  function automatic tightener_item_t bound_item(pbt_pkg::op_e op, logic [7:0] first_idx,
                                                 logic [7:0] second_idx, int distance);
    tightener_item_t it;
    it           = scrambled_item();
    it.op        = op;
    it.cell_idx  = first_idx;
    it.other_idx = second_idx;
    it.distance  = distance;
    return it;
  endfunction

  function automatic tightener_item_t read_item(logic [7:0] cell_idx);
    tightener_item_t it;
    it          = scrambled_item();
    it.op       = pbt_pkg::OP_READ;
    it.cell_idx = cell_idx;
    return it;
  endfunction

  // Mostly moderate coordinates so constraints bite, with the range ends mixed in.
  function automatic int rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0: v = BOUND_MAX;
      1: v = BOUND_MIN;
      2: v = int'($urandom);
      3, 4: v = int'($urandom_range(0, 200)) - 100;
      default: v = int'($urandom_range(0, 2000000)) - 1000000;
    endcase
    return v;
  endfunction

  // Upper bound for a given lower bound: usually a well-formed box, sometimes not.
  function automatic int spread_from(int lo);
    if ($urandom_range(0, 4) == 0) begin
      return rand_coord();
    end
    return box_scoreboard::clamp32(longint'(lo) + longint'($urandom_range(0, 100000)));
  endfunction

  function automatic logic [15:0] rand_pitch();
    logic [15:0] p;
    case ($urandom_range(0, 19))
      0: p = 16'd0;
      1: p = 16'hFFFF;
      2, 3, 4: p = 16'($urandom_range(1, 65535));
      default: p = 16'($urandom_range(1, 64));
    endcase
    return p;
  endfunction

  function automatic int rand_distance();
    int d;
    case ($urandom_range(0, 9))
      0: d = BOUND_MAX;
      1: d = BOUND_MIN;
      2: d = int'($urandom);
      3: d = -int'($urandom_range(0, 5000));
      default: d = int'($urandom_range(0, 5000));
    endcase
    return d;
  endfunction

  function automatic logic [7:0] pick_loaded();
    return loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
  endfunction

  function automatic tightener_item_t random_item();
    int unsigned roll;
    logic [7:0]  cell_idx;
    int          xlo;
    int          ylo;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      // revisit a small hot set of cells most of the time so constraints chain
      cell_idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31)) : 8'($urandom);
      xlo = rand_coord();
      ylo = rand_coord();
      return load_item(cell_idx, xlo, spread_from(xlo), ylo, spread_from(ylo),
                       rand_pitch(), rand_pitch());
    end
    if (roll < 65) begin
      return bound_item(($urandom_range(0, 1) == 0) ? pbt_pkg::OP_XCON : pbt_pkg::OP_YCON,
                        pick_loaded(), pick_loaded(), rand_distance());
    end
    return read_item(pick_loaded());
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic offer_item(input tightener_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    op_i           <= it.op;
    cell_index_i   <= it.cell_idx;
    other_index_i  <= it.other_idx;
    min_distance_i <= it.distance;
    load_xmin_i    <= it.xmin;
    load_xmax_i    <= it.xmax;
    load_ymin_i    <= it.ymin;
    load_ymax_i    <= it.ymax;
    load_x_pitch_i <= it.px;
    load_y_pitch_i <= it.py;
    // hold the payload until the block takes it
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    boxes.note_item(it);
    if (it.op == pbt_pkg::OP_LOAD && !cell_loaded[it.cell_idx]) begin
      cell_loaded[it.cell_idx] = 1'b1;
      loaded_cells.push_back(it.cell_idx);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on changing patterns, plus one long hold-off that backs the
  // block up while the sender keeps offering items
  // ---------------------------------------------------------------------------
  initial begin : receiver_stalls
    int unsigned    cycle_count;
    int unsigned    hold_left;
    int unsigned    pattern_left;
    stall_pattern_e pattern;
    cycle_count  = 0;
    hold_left    = 0;
    pattern_left = 0;
    pattern      = STALL_NONE;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count == HOLD_START) begin
        hold_left = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern      = stall_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 300);
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (pattern)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 1) == 0);
          default:     out_stall_i <= ((cycle_count % 8) < 5);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare every accepted box with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      boxes.check_box(snapped_box_t'{out_index_o, out_xmin_o, out_xmax_o,
                                     out_ymin_o, out_ymax_o});
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    boxes          = new();
    burst_left     = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = pbt_pkg::OP_LOAD;
    cell_index_i   = '0;
    other_index_i  = '0;
    min_distance_i = '0;
    load_xmin_i    = '0;
    load_xmax_i    = '0;
    load_ymin_i    = '0;
    load_ymax_i    = '0;
    load_x_pitch_i = '0;
    load_y_pitch_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Range ends of the box and of the pitch; cell 255 snaps past both range ends.
    offer_item(load_item(8'd0, -7, 23, BOUND_MIN, BOUND_MAX, 16'd5, 16'hFFFF));
    offer_item(load_item(8'd255, BOUND_MAX - 1, BOUND_MIN + 1, BOUND_MAX, BOUND_MIN,
                         16'hFFFF, 16'd7));
    // zero pitch: bounds come back unrounded
    offer_item(load_item(8'd1, -1, 1, 0, 0, 16'd0, 16'd0));
    offer_item(load_item(8'd2, -13, 13, -1, -1, 16'd1, 16'd4));
    offer_item(read_item(8'd0));
    offer_item(read_item(8'd255));
    offer_item(read_item(8'd1));
    offer_item(read_item(8'd2));

    // Sums that overflow both ways, a cell constrained against itself, zero distance.
    offer_item(bound_item(pbt_pkg::OP_XCON, 8'd255, 8'd0, BOUND_MAX));
    offer_item(bound_item(pbt_pkg::OP_YCON, 8'd0, 8'd255, BOUND_MIN));
    offer_item(bound_item(pbt_pkg::OP_YCON, 8'd2, 8'd0, BOUND_MIN));
    offer_item(bound_item(pbt_pkg::OP_XCON, 8'd2, 8'd2, -5));
    offer_item(bound_item(pbt_pkg::OP_YCON, 8'd1, 8'd2, 3));
    offer_item(bound_item(pbt_pkg::OP_XCON, 8'd2, 8'd1, 0));
    offer_item(read_item(8'd0));
    offer_item(read_item(8'd255));
    offer_item(read_item(8'd1));
    offer_item(read_item(8'd2));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      offer_item(random_item());
    end
    in_valid_i <= 1'b0;

    // drain the outstanding boxes, then give a late stray result time to show up
    while (boxes.pending_boxes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (boxes.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
